// ----- rtl/core/mcd_pkg.sv -----
package mcd_pkg;

  localparam int MAX_LEN = 1024;
  localparam int LEN_W = 10;
  localparam int ADDR_W = $clog2(MAX_LEN);
  localparam int ENTRY_W = LEN_W + 1;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PIECE_LEN_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIECE_LEN_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIECE_LEN_C = 2'd2;

  typedef struct packed {
    logic init;
    logic rd;
    logic calc;
    logic zero_done;
  } ctrl_cmd_t;

  typedef struct packed {
    logic trivial;
    logic last;
  } dp_sts_t;

endpackage

// ----- rtl/core/mcd_ram.sv -----
module mcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/mcd_ctrl.sv -----
module mcd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  mcd_pkg::dp_sts_t   sts,
  output mcd_pkg::ctrl_cmd_t cmd,
  output logic               busy
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_CALC = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd.init      = 1'b0;
    cmd.rd        = 1'b0;
    cmd.calc      = 1'b0;
    cmd.zero_done = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (sts.trivial) begin
            cmd.zero_done = 1'b1;
          end else begin
            cmd.init  = 1'b1;
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = sts.last ? ST_IDLE : ST_READ;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  a_rd_then_calc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |=> cmd.calc)
    else $error("read not followed by compute");

  a_calc_not_twice: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.calc |=> !cmd.calc)
    else $error("compute issued twice in a row");

  a_calc_loops: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.calc && !sts.last) |=> cmd.rd)
    else $error("table walk stopped early");

  a_init_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.init || cmd.zero_done) |-> (start && !busy))
    else $error("item started while busy");

endmodule

// ----- rtl/core/mcd_dp.sv -----
module mcd_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mcd_pkg::ctrl_cmd_t              cmd,
  output mcd_pkg::dp_sts_t                sts,
  input  logic                            cfg_we,
  input  logic [mcd_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [mcd_pkg::LEN_W-1:0]       cfg_wdata,
  input  logic [mcd_pkg::LEN_W-1:0]       in_total_len,
  output logic                            out_valid,
  output logic [mcd_pkg::LEN_W-1:0]       out_piece_count
);

  localparam int LW = mcd_pkg::LEN_W;
  localparam int AW = mcd_pkg::ADDR_W;
  localparam int EW = mcd_pkg::ENTRY_W;

  logic [LW-1:0] len_a_r, len_b_r, len_c_r;
  logic [LW-1:0] n_r, i_r, i_nxt;
  logic          out_valid_r;
  logic [LW-1:0] out_count_r;

  logic [2:0][LW-1:0] plen;
  logic [2:0][AW-1:0] raddr;
  logic [2:0][EW-1:0] rdata;
  logic [2:0]         use_src;

  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic          found;
  logic [LW-1:0] best;
  logic [LW-1:0] cand;

  assign plen = {len_c_r, len_b_r, len_a_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_a_r <= LW'(1);
      len_b_r <= LW'(1);
      len_c_r <= LW'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        mcd_pkg::CFG_PIECE_LEN_A: len_a_r <= cfg_wdata;
        mcd_pkg::CFG_PIECE_LEN_B: len_b_r <= cfg_wdata;
        mcd_pkg::CFG_PIECE_LEN_C: len_c_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign sts.trivial = (in_total_len == '0) || (32'(in_total_len) >= mcd_pkg::MAX_LEN);
  assign sts.last    = (i_r == n_r);

  always_comb begin
    found = 1'b0;
    best  = '0;
    cand  = '0;
    for (int k = 0; k < 3; k++) begin
      use_src[k] = (plen[k] != '0) && (plen[k] <= i_r) && rdata[k][EW-1];
      cand = rdata[k][LW-1:0] + LW'(1);
      if (use_src[k] && (!found || cand > best)) begin
        best  = cand;
        found = 1'b1;
      end
    end
  end

  always_comb begin
    we    = cmd.init || cmd.calc;
    waddr = cmd.init ? '0 : AW'(i_r);
    wdata = cmd.init ? {1'b1, LW'(0)} : (found ? {1'b1, best} : '0);
  end

  always_comb begin
    i_nxt = i_r;
    if (cmd.init) begin
      i_nxt = LW'(1);
    end else if (cmd.calc) begin
      i_nxt = i_r + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    if (cmd.init) begin
      n_r <= in_total_len;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_port
    assign raddr[g] = AW'(i_r - plen[g]);
    mcd_ram #(
      .WIDTH(EW),
      .DEPTH(mcd_pkg::MAX_LEN)
    ) u_ram (
      .clk  (clk),
      .we   (we),
      .waddr(waddr),
      .wdata(wdata),
      .re   (cmd.rd),
      .raddr(raddr[g]),
      .rdata(rdata[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.zero_done || (cmd.calc && sts.last);
    end
    if (cmd.zero_done) begin
      out_count_r <= '0;
    end else if (cmd.calc && sts.last) begin
      out_count_r <= found ? best : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_piece_count = out_count_r;

  a_strobe_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(cmd.zero_done || (cmd.calc && sts.last)))
    else $error("result strobe without finished item");

  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.zero_done |=> (out_valid_r && out_count_r == '0))
    else $error("trivial item gave nonzero count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.calc && found) |-> (best <= i_r))
    else $error("piece count exceeds length");

endmodule

// ----- rtl/core/max_segment_count_dp.sv -----
// Channel   Ports                                        Handshake
// input     start, busy, in_total_len[9:0]               accepted when start && !busy
// result    out_valid, out_piece_count[9:0]              one-cycle strobe, no stall
// config    cfg_we, cfg_idx[1:0], cfg_wdata[9:0]         written when cfg_we
//
// The result strobe is registered from the compute of the last table entry, or from the accept when total_len is 0.
// Each table entry is built by a registered read of the three source entries
// from the table RAM copies, then the compare and the write of the new entry.
// busy is low again in the cycle of the result strobe.
// rst_n is synchronous; piece lengths reset to 1, the table needs no clearing.
// The receiver cannot stall; results are never held.
module max_segment_count_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [mcd_pkg::LEN_W-1:0]       in_total_len,
  output logic                            out_valid,
  output logic [mcd_pkg::LEN_W-1:0]       out_piece_count,
  input  logic                            cfg_we,
  input  logic [mcd_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [mcd_pkg::LEN_W-1:0]       cfg_wdata
);

  mcd_pkg::ctrl_cmd_t cmd;
  mcd_pkg::dp_sts_t   sts;

  mcd_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .sts  (sts),
    .cmd  (cmd),
    .busy (busy)
  );

  mcd_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .in_total_len   (in_total_len),
    .out_valid      (out_valid),
    .out_piece_count(out_piece_count)
  );

endmodule
